>>> rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 RGB box blur
// Word formats, register indexes, controller states, command and status
// groups, and the reciprocal table used to divide by the window size.
// ----------------------------------------------------------------------------
package bb3_pkg;

  // Widths fixed by the word formats.
  localparam int CHAN_W      = 8;
  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int POS_W       = 10;

  // Window sums: nine 8-bit values fit in 12 bits, 2*sum + count in 13.
  localparam int SUM_W   = 12;
  localparam int NUMER_W = 13;
  localparam int COUNT_W = 4;

  // Division by 2*count is a multiply by ceil(2^18 / (2*count)).
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = NUMER_W + RECIP_W;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // One input pixel, also the format of a line buffer entry.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // One blurred output pixel.
  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_column;
    logic              last;
  } result_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  // kind[0] moves the window one column right, kind[1] one row down.
  typedef struct packed {
    logic       cfg_write;
    logic       accept;
    logic       load;
    logic       sum;
    logic [1:0] kind;
    logic       last;
    logic       mul;
    logic       load_out;
  } bb3_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [3:0] pending;
    logic       out_free;
  } bb3_status_t;

  // Reciprocal of twice the pixel count, scaled by 2^RECIP_SHIFT and rounded up.
  function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
    logic [RECIP_W-1:0] m;
    case (count)
      4'd1: m = 18'd131072;
      4'd2: m = 18'd65536;
      4'd3: m = 18'd43691;
      4'd4: m = 18'd32768;
      4'd6: m = 18'd21846;
      4'd9: m = 18'd14564;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// bb3_ctrl: sequencing controller of the 3x3 RGB box blur
// Accepts one pixel at a time, loads the window, then steps the datapath
// through sum, multiply and output for every finished position.
// ----------------------------------------------------------------------------
module bb3_ctrl
  import bb3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  bb3_status_t status,
  output bb3_cmd_t    cmd
);

  state_t     state;
  state_t     state_next;
  logic [3:0] pending;
  logic [3:0] pending_next;
  logic [3:0] sel;
  logic [1:0] sel_kind;

  // Lowest pending position goes first, which keeps raster order.
  assign sel = pending & (~pending + 4'd1);

  always_comb begin
    if (sel[1]) begin
      sel_kind = 2'd1;
    end else if (sel[2]) begin
      sel_kind = 2'd2;
    end else if (sel[3]) begin
      sel_kind = 2'd3;
    end else begin
      sel_kind = 2'd0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pixel_valid && !cfg_valid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.pending != 4'd0) state_next = ST_SUM;
        else                        state_next = ST_IDLE;
      end
      ST_SUM:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_OUT;
      ST_OUT: begin
        if (status.out_free) begin
          if (pending != 4'd0) state_next = ST_SUM;
          else                 state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Pending positions of the current pixel.
  always_comb begin
    pending_next = pending;
    case (state)
      ST_LOAD: pending_next = status.pending;
      ST_SUM:  pending_next = pending & ~sel;
      default: pending_next = pending;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd         = '0;
    pixel_stall = 1'b1;
    cfg_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        // A configuration write wins over a pixel in the same cycle.
        cfg_ready     = 1'b1;
        pixel_stall   = cfg_valid;
        cmd.cfg_write = cfg_valid;
        cmd.accept    = pixel_valid && !cfg_valid;
      end
      ST_LOAD: cmd.load = 1'b1;
      ST_SUM: begin
        cmd.sum  = 1'b1;
        cmd.kind = sel_kind;
        cmd.last = (pending & ~sel) == 4'd0;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_OUT:  cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 4'd0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

endmodule

>>> rtl/bb3_datapath.sv
// ----------------------------------------------------------------------------
// bb3_datapath: line buffers, window and arithmetic of the 3x3 RGB box blur
// Holds the configuration, raster counters, two line memories, the 3x3
// window, the masked window sum, the reciprocal multiply and the output word.
// ----------------------------------------------------------------------------
module bb3_datapath
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bb3_cmd_t               cmd,
  output bb3_status_t            status,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  pixel_t                 pixel,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Configuration and raster position of the next pixel.
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CW-1:0]    w_last;
  logic [RW-1:0]    h_last;
  logic [CW-1:0]    column_count;
  logic [RW-1:0]    row_count;
  logic             cfg_hit;

  // Current pixel and its position.
  pixel_t        item_pix;
  logic [CW-1:0] item_c;
  logic [RW-1:0] item_r;

  // Line memories and their registered read data.
  pixel_t older_line [MAX_WIDTH];
  pixel_t newer_line [MAX_WIDTH];
  pixel_t older_rd;
  pixel_t newer_rd;

  // Window indexed [column][row]; column 2 and row 2 are the current pixel.
  pixel_t win_px [3][3];

  // Sum stage.
  logic [2:0]         col_mask;
  logic [2:0]         row_mask;
  logic [1:0]         ncol;
  logic [1:0]         nrow;
  logic [COUNT_W-1:0] count;
  logic [SUM_W-1:0]   sum_red;
  logic [SUM_W-1:0]   sum_green;
  logic [SUM_W-1:0]   sum_blue;
  logic [CW-1:0]      pos_c;
  logic [RW-1:0]      pos_r;
  logic [NUMER_W-1:0] x_red;
  logic [NUMER_W-1:0] x_green;
  logic [NUMER_W-1:0] x_blue;
  logic [RECIP_W-1:0] recip_m;
  logic [POS_W-1:0]   s_row;
  logic [POS_W-1:0]   s_column;
  logic               s_last;

  // Multiply stage.
  logic [PROD_W-1:0]  prod_red;
  logic [PROD_W-1:0]  prod_green;
  logic [PROD_W-1:0]  prod_blue;
  logic [CHAN_W-1:0]  q_red;
  logic [CHAN_W-1:0]  q_green;
  logic [CHAN_W-1:0]  q_blue;
  logic [POS_W-1:0]   m_row;
  logic [POS_W-1:0]   m_column;
  logic               m_last;

  // Clipped sizes as last index; zero acts as one, oversize as the maximum.
  always_comb begin
    if (image_width == '0) begin
      w_last = '0;
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(image_width - 11'd1);
    end
    if (image_height == '0) begin
      h_last = '0;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(image_height - 11'd1);
    end
  end

  assign cfg_hit = cmd.cfg_write &&
                   (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

  // Registers and raster counters; a write to either size register restarts the image.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1);
      image_height <= CFG_W'(1);
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == CFG_IMAGE_WIDTH) image_width <= cfg_data;
      else                              image_height <= cfg_data;
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.accept) begin
      if (column_count == w_last) begin
        column_count <= '0;
        if (row_count == h_last) row_count <= '0;
        else                     row_count <= row_count + RW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // Capture the accepted pixel and its position.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_pix <= pixel;
      item_c   <= column_count;
      item_r   <= row_count;
    end
  end

  // Line memories: read at accept, written back in the load cycle right after it.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      older_rd <= older_line[column_count];
      newer_rd <= newer_line[column_count];
    end
    if (cmd.load) begin
      older_line[item_c] <= newer_rd;
      newer_line[item_c] <= item_pix;
    end
  end

  // Shift the window left and bring in the new column.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < 3; j++) begin
        win_px[0][j] <= win_px[1][j];
        win_px[1][j] <= win_px[2][j];
      end
      win_px[2][0] <= older_rd;
      win_px[2][1] <= newer_rd;
      win_px[2][2] <= item_pix;
    end
  end

  // Positions that this pixel completes, in raster order.
  always_comb begin
    status.pending[0] = (item_r != '0) && (item_c != '0);
    status.pending[1] = (item_r != '0) && (item_c == w_last);
    status.pending[2] = (item_r == h_last) && (item_c != '0);
    status.pending[3] = (item_r == h_last) && (item_c == w_last);
    status.out_free   = !result_valid || !result_stall;
  end

  // Clip the window at the image borders.
  always_comb begin
    col_mask[0] = !cmd.kind[0] && (item_c > CW'(1));
    col_mask[1] = cmd.kind[0] ? (item_c != '0) : 1'b1;
    col_mask[2] = 1'b1;
    row_mask[0] = !cmd.kind[1] && (item_r > RW'(1));
    row_mask[1] = cmd.kind[1] ? (item_r != '0) : 1'b1;
    row_mask[2] = 1'b1;
    ncol  = 2'd1 + 2'(col_mask[0]) + 2'(col_mask[1]);
    nrow  = 2'd1 + 2'(row_mask[0]) + 2'(row_mask[1]);
    count = COUNT_W'(ncol) * COUNT_W'(nrow);
    pos_c = cmd.kind[0] ? item_c : item_c - CW'(1);
    pos_r = cmd.kind[1] ? item_r : item_r - RW'(1);
  end

  // Masked sum over the nine window pixels.
  always_comb begin
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (col_mask[i] && row_mask[j]) begin
          sum_red   = sum_red   + SUM_W'(win_px[i][j].red);
          sum_green = sum_green + SUM_W'(win_px[i][j].green);
          sum_blue  = sum_blue  + SUM_W'(win_px[i][j].blue);
        end
      end
    end
  end

  // Sum stage register: numerator 2*sum + count and the matching reciprocal.
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      x_red    <= NUMER_W'({sum_red, 1'b0}) + NUMER_W'(count);
      x_green  <= NUMER_W'({sum_green, 1'b0}) + NUMER_W'(count);
      x_blue   <= NUMER_W'({sum_blue, 1'b0}) + NUMER_W'(count);
      recip_m  <= recip(count);
      s_row    <= POS_W'(pos_r);
      s_column <= POS_W'(pos_c);
      s_last   <= cmd.last;
    end
  end

  // Divide by 2*count as a multiply by its scaled reciprocal.
  assign prod_red   = PROD_W'(x_red)   * PROD_W'(recip_m);
  assign prod_green = PROD_W'(x_green) * PROD_W'(recip_m);
  assign prod_blue  = PROD_W'(x_blue)  * PROD_W'(recip_m);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      q_red    <= prod_red[RECIP_SHIFT +: CHAN_W];
      q_green  <= prod_green[RECIP_SHIFT +: CHAN_W];
      q_blue   <= prod_blue[RECIP_SHIFT +: CHAN_W];
      m_row    <= s_row;
      m_column <= s_column;
      m_last   <= s_last;
    end
  end

  // Output register; it holds its word while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.out_red    <= q_red;
      result.out_green  <= q_green;
      result.out_blue   <= q_blue;
      result.out_row    <= m_row;
      result.out_column <= m_column;
      result.last       <= m_last;
    end
  end

endmodule

>>> rtl/box_blur_3x3_rgb_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core: streaming 3x3 box blur over RGB pixels
// Averages the in-bounds 3x3 neighborhood of every pixel of a raster image,
// rounding half up, and emits the blurred pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the pixel channel (valid/stall); each
//   accepted word is one RGB pixel. Blurred pixels leave on the result
//   channel with their row and column; last marks the final word that an
//   input pixel produces. A pixel produces zero to four words, the extra
//   ones at the end of a row and in the last row of the image.
//   The cfg channel (valid/ready) writes image_width (index 0) and
//   image_height (index 1); a write restarts the image at row 0, column 0.
// Sequence:
//   One pixel is processed at a time. A pixel passes through the line
//   memory read at accept and the window load, then through sum, multiply
//   and output for every word it produces. The first word becomes valid
//   once it has passed the load, sum, multiply and output steps.
// Reset and stall:
//   Reset sets both sizes to 1, the position to (0,0) and empties the output
// register. The line memories are not cleared; an entry is used only after
//   it was written in the current image. While the result channel stalls the
//   output word holds and the block waits before loading the next word; the
//   next pixel is accepted while the last word of a pixel is still waiting.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  pixel_t                 pixel,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  bb3_cmd_t    cmd;
  bb3_status_t status;

  bb3_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .status      (status),
    .cmd         (cmd)
  );

  bb3_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // A new word never overwrites one that the receiver has not taken.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result_valid || !result_stall))
    else $error("output word overwritten while stalled");

  // Only one pixel is in work at a time.
  a_one_pixel : assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall) |=> pixel_stall)
    else $error("pixel accepted while another is in work");

  // The controller issues at most one datapath step per cycle.
  a_one_step : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.cfg_write, cmd.accept, cmd.load, cmd.sum, cmd.mul, cmd.load_out}))
    else $error("conflicting datapath commands");

endmodule

>>> sim/box_blur_3x3_rgb_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core_tb: self-checking bench for the 3x3 RGB box blur
// Streams raster images of many sizes through the core. These include the
// zero and oversize settings, restarts by register writes, and images that
// wrap around. Every blurred word is checked against a local model of the
// clipped window mean. Both channels idle at random, and one long output
// hold makes the core stall its pixel input.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core_tb;
  import bb3_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;

  logic clk;
  logic rst = 1'b1;

  logic                   pixel_valid = 1'b0;
  logic                   pixel_stall;
  pixel_t                 pixel = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0]       cfg_data = '0;

  // Pixels waiting to be offered, and blurred words still owed by the core.
  pixel_t  pixel_q [$];
  result_t blurred_due [$];

  int pixels_sent = 0;
  int pixels_in   = 0;
  int cfg_writes  = 0;
  int mismatches  = 0;
  bit pix_taken   = 1'b0;

  // Idling control: calm turns idling off, hold_left counts the long hold.
  bit calm      = 1'b0;
  bit hold_arm  = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  // Local copy of the blur state and of the image size registers.
  pixel_t           older_rows [MAX_W];
  pixel_t           newer_rows [MAX_W];
  pixel_t           win_cols [6];
  pixel_t           nbhd [3][3];
  int unsigned      next_col;
  int unsigned      next_row;
  logic [CFG_W-1:0] img_width;
  logic [CFG_W-1:0] img_height;

  box_blur_3x3_rgb_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Rounded mean of the window columns lc..lc+2 and rows lr..lr+2 of nbhd,
  // leaving out the outer column or row whose flag is clear.
  function automatic result_t window_mean(int lc, bit vl, bit vr, int lr, bit vu, bit vd,
                                          int unsigned row, int unsigned col);
    int unsigned sr, sg, sb, n;
    int          dc, dr, ci, ri;
    result_t     res;
    sr = 0;
    sg = 0;
    sb = 0;
    n  = 0;
    for (dc = 0; dc < 3; dc++) begin
      ci = lc + dc;
      if ((dc == 0 && !vl) || (dc == 2 && !vr) || ci > 2) continue;
      for (dr = 0; dr < 3; dr++) begin
        ri = lr + dr;
        if ((dr == 0 && !vu) || (dr == 2 && !vd) || ri > 2) continue;
        sr += nbhd[ci][ri].red;
        sg += nbhd[ci][ri].green;
        sb += nbhd[ci][ri].blue;
        n++;
      end
    end
    // Half-up rounding; a mean of 8-bit values never exceeds 255.
    res.out_red    = CHAN_W'((2 * sr + n) / (2 * n));
    res.out_green  = CHAN_W'((2 * sg + n) / (2 * n));
    res.out_blue   = CHAN_W'((2 * sb + n) / (2 * n));
    res.out_row    = POS_W'(row);
    res.out_column = POS_W'(col);
    res.last       = 1'b0;
    return res;
  endfunction

  // Advances the local blur state by one pixel and queues the words it completes.
  task automatic blur_pixel(input pixel_t px);
    int unsigned w, h, r, c, k, i;
    result_t     outs [4];
    w = (img_width == 0) ? 1 : (img_width > MAX_W) ? MAX_W : img_width;
    h = (img_height == 0) ? 1 : (img_height > MAX_H) ? MAX_H : img_height;
    r = next_row;
    c = next_col;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    for (i = 0; i < 3; i++) begin
      nbhd[0][i] = win_cols[i];
      nbhd[1][i] = win_cols[3 + i];
    end
    nbhd[2][0] = older_rows[c];
    nbhd[2][1] = newer_rows[c];
    nbhd[2][2] = px;
    older_rows[c] = nbhd[2][1];
    newer_rows[c] = px;

    // Positions finished by this pixel, in raster order.
    k = 0;
    if (r >= 1 && c >= 1) begin
      outs[k] = window_mean(0, c >= 2, 1'b1, 0, r >= 2, 1'b1, r - 1, c - 1);
      k++;
    end
    if (r >= 1 && c == w - 1) begin
      outs[k] = window_mean(1, c >= 1, 1'b0, 0, r >= 2, 1'b1, r - 1, c);
      k++;
    end
    if (r == h - 1 && c >= 1) begin
      outs[k] = window_mean(0, c >= 2, 1'b1, 1, r >= 1, 1'b0, r, c - 1);
      k++;
    end
    if (r == h - 1 && c == w - 1) begin
      outs[k] = window_mean(1, c >= 1, 1'b0, 1, r >= 1, 1'b0, r, c);
      k++;
    end
    if (k > 0) outs[k - 1].last = 1'b1;
    for (i = 0; i < k; i++) blurred_due.push_back(outs[i]);

    for (i = 0; i < 3; i++) begin
      win_cols[i]     = nbhd[1][i];
      win_cols[3 + i] = nbhd[2][i];
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endtask

  // Compares one accepted blurred word with the oldest one owed.
  task automatic check_word(input result_t got);
    result_t want;
    if (blurred_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected word: rgb %0d %0d %0d at (%0d,%0d) last %0b",
                 got.out_red, got.out_green, got.out_blue, got.out_row,
                 got.out_column, got.last);
    end else begin
      want = blurred_due.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.out_row !== want.out_row ||
          got.out_column !== want.out_column || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected rgb %0d %0d %0d at (%0d,%0d) last %0b, %s",
                   want.out_red, want.out_green, want.out_blue, want.out_row,
                   want.out_column, want.last,
                   $sformatf("got rgb %0d %0d %0d at (%0d,%0d) last %0b",
                             got.out_red, got.out_green, got.out_blue,
                             got.out_row, got.out_column, got.last));
      end
    end
  endtask

  // Monitor: checks blurred words and tracks every accepted word at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      pix_taken  <= 1'b0;
      img_width  = 1;
      img_height = 1;
      next_col   = 0;
      next_row   = 0;
      foreach (win_cols[i]) win_cols[i] = '0;
      foreach (older_rows[i]) begin
        older_rows[i] = '0;
        newer_rows[i] = '0;
      end
    end else begin
      pix_taken <= pixel_valid && !pixel_stall;
      if (result_valid && !result_stall) check_word(result);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            img_width = cfg_data;
            next_col  = 0;
            next_row  = 0;
          end
          CFG_IMAGE_HEIGHT: begin
            img_height = cfg_data;
            next_col   = 0;
            next_row   = 0;
          end
          default: ;
        endcase
        cfg_writes <= cfg_writes + 1;
      end
      if (pixel_valid && !pixel_stall) begin
        blur_pixel(pixel);
        pixels_in <= pixels_in + 1;
      end
    end
  end

  // Driver: offers the next pixel word at the falling edge, idling at random.
  always @(negedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || pix_taken) begin
      if (pixel_q.size() != 0 && (calm || hold_left != 0 || $urandom_range(99) >= 36)) begin
        pixel       <= pixel_q.pop_front();
        pixel_valid <= 1'b1;
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Long output hold, started once so that the core backs up into its input.
  always @(negedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_left <= 200;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall: random, except during the hold and in the calm phase.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 36);
    end
  end

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.red   = 8'($urandom);
    px.green = 8'($urandom);
    px.blue  = 8'($urandom);
    case ($urandom_range(9))
      0: px = '0;
      1: px = '1;
      2: begin
        px.red   = '0;
        px.green = '1;
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic queue_pixel(input pixel_t px);
    pixel_q.push_back(px);
    pixels_sent++;
  endtask

  task automatic queue_random(input int count);
    repeat (count) queue_pixel(random_pixel());
  endtask

  // Waits until every pixel is in and every word is out, then lets the core
  // finish a pixel that produces no word.
  task automatic wait_drained();
    @(negedge clk);
    while (pixels_in != pixels_sent || blurred_due.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    int n0;
    @(negedge clk);
    n0        = cfg_writes;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_W'(val);
    while (cfg_writes == n0) @(negedge clk);
    cfg_valid = 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input int w, input int h);
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // Stimulus: directed images first, then the size extremes, then random images.
  initial begin
    int ww, hh, sel, area, n, left, phase;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // Reset size is 1x1, so each pixel is a whole image of its own.
    queue_pixel('0);
    queue_pixel('1);

    // A zero width and height behave as 1.
    set_size(0, 0);
    queue_pixel('{8'h80, 8'h01, 8'hFE});

    // Checkerboard of full and empty pixels: every clipped window size shows
    // up, and the corners round a half upward.
    set_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      if (i % 2 == 0) queue_pixel('1);
      else queue_pixel('0);
    end
    // Start a second image, then cut it short with a register write.
    queue_random(4);
    wait_drained();
    write_reg(CFG_IMAGE_HEIGHT, 2);
    queue_random(6);

    // Oversize width, then oversize height; both clip to the maximum.
    set_size(2047, 1);
    queue_random(6);
    set_size(1, 2047);
    queue_random(6);
    set_size(1024, 1024);
    queue_random(4);

    // Random images, mostly whole ones, some cut short by the next write.
    left  = 240;
    phase = 0;
    ww    = 1024;
    hh    = 1024;
    while (left > 0) begin
      wait_drained();
      calm = 1'b0;
      sel  = 2;
      if (phase == 0) begin
        ww = 8;
        hh = 6;
      end else if (phase == 1) begin
        ww = 10;
        hh = 5;
      end else begin
        sel = $urandom_range(4);
        if (sel != 1) ww = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
        if (sel != 0) hh = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (sel != 1) write_reg(CFG_IMAGE_WIDTH, ww);
      if (sel != 0) write_reg(CFG_IMAGE_HEIGHT, hh);
      area = ((ww == 0) ? 1 : ww) * ((hh == 0) ? 1 : hh);
      if (phase >= 2 && $urandom_range(3) == 0) n = $urandom_range(1, area);
      else n = area * $urandom_range(1, 2);
      if (phase == 0) hold_arm = 1'b1;
      if (phase == 1) calm = 1'b1;
      queue_random(n);
      left -= n;
      phase++;
    end

    wait_drained();
    if (mismatches == 0 && blurred_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
